FILE: hdl/sliding_window_median_top_defines.svh
// Assertion macros used by the checker file of the median filter.
// No dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Check held off while reset is asserted.
`define SWM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");

// Check that also covers the reset cycles.
`define SWM_ASSERT_ANY(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

FILE: hdl/swm_pkg.sv
// Shared constants, types and helpers for the sliding window median filter.
// No dependencies.
package swm_pkg;

    localparam int MAX_WINDOW   = 32;
    localparam int SAMPLE_WIDTH = 32;
    localparam int IDX_W        = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int CFG_W        = 6;
    localparam int OUT_W        = 33;
    localparam int IN_W         = 32;

    localparam logic [CFG_W-1:0] WSIZE_RESET = CFG_W'(3);

    typedef logic signed [SAMPLE_WIDTH-1:0] t_sample;
    typedef logic signed [OUT_W-1:0]        t_median;

    // Broadcast to every cell for one request
    typedef struct packed {
        logic             load;    // request accepted this cycle
        logic             remove;  // window full: drop one copy of x
        logic [CNT_W-1:0] held;    // entries held before this request
        t_sample          s;       // new sample
        t_sample          x;       // oldest sample, evicted when full
        logic [IDX_W-1:0] mid;     // upper middle tap
        logic [IDX_W-1:0] lo;      // lower middle tap (same as mid for odd)
    } t_cell_ctl;

    // Exchanged between neighbor cells
    typedef struct packed {
        logic lt;  // held and smaller than the new sample
        logic ge;  // window full, held and at or above the evicted sample
    } t_cell_flags;

    // Window length as used: zero reads as one, large values saturate.
    function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] w);
        logic [CNT_W-1:0] k;
        if (w == '0) begin
            k = CNT_W'(1);
        end else if (int'(w) > MAX_WINDOW) begin
            k = CNT_W'(MAX_WINDOW);
        end else begin
            k = CNT_W'(w);
        end
        return k;
    endfunction

endpackage

FILE: hdl/swm_if.sv
// Handshake channels of the median filter: sample requests in, medians out.
// Depends on swm_pkg.
interface swm_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::IN_W-1:0]     sample;
    logic                                start_new;

    modport source (output valid, output sample, output start_new, input ready);
    modport sink   (input valid, input sample, input start_new, output ready);
endinterface

interface swm_median_if;
    logic                                valid;
    logic                                ready;
    logic signed [swm_pkg::OUT_W-1:0]    median_twice;

    modport source (output valid, output median_twice, input ready);
    modport sink   (input valid, input median_twice, output ready);
endinterface

FILE: hdl/swm_cell.sv
// One slot of the sorted chain: holds one value, removes and inserts locally.
// Depends on swm_pkg.
module swm_cell (
    input  logic                        i_clk,
    input  logic [swm_pkg::IDX_W-1:0]   i_index,
    input  swm_pkg::t_cell_ctl          i_ctl,
    input  swm_pkg::t_sample            i_lo_val,
    input  swm_pkg::t_cell_flags        i_lo_flags,
    input  swm_pkg::t_sample            i_hi_val,
    input  logic                        i_hi_lt,
    output swm_pkg::t_sample            o_val,
    output swm_pkg::t_cell_flags        o_flags,
    output swm_pkg::t_sample            o_mid_tap,
    output swm_pkg::t_sample            o_lo_tap
);
    import swm_pkg::*;

    t_sample r_val;
    t_sample n_val;
    logic    held;
    t_sample rem_val;
    logic    rem_lt;
    t_sample lo_rem_val;
    logic    lo_rem_lt;

    assign held       = CNT_W'(i_index) < i_ctl.held;
    assign o_flags.lt = held && (r_val < i_ctl.s);
    assign o_flags.ge = i_ctl.remove && held && (r_val >= i_ctl.x);

    // List after removal, at this slot and at the one below
    assign rem_val    = o_flags.ge ? i_hi_val : r_val;
    assign rem_lt     = o_flags.ge ? i_hi_lt : o_flags.lt;
    assign lo_rem_val = i_lo_flags.ge ? r_val : i_lo_val;
    assign lo_rem_lt  = i_lo_flags.ge ? o_flags.lt : i_lo_flags.lt;

    // Keep if smaller, take the sample at the insert point, else shift up
    always_comb begin
        if (rem_lt) begin
            n_val = rem_val;
        end else if (lo_rem_lt) begin
            n_val = i_ctl.s;
        end else begin
            n_val = lo_rem_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_val <= n_val;
        end
    end

    assign o_val     = r_val;
    assign o_mid_tap = (i_index == i_ctl.mid) ? r_val : '0;
    assign o_lo_tap  = (i_index == i_ctl.lo) ? r_val : '0;

endmodule

FILE: hdl/swm_ring.sv
// Arrival-order history and ring pointer; prefetches the next evicted sample.
// Depends on swm_pkg.
module swm_ring (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_start,
    input  logic                        i_clear,
    input  logic [swm_pkg::CNT_W-1:0]   i_k,
    input  swm_pkg::t_sample            i_s,
    output swm_pkg::t_sample            o_evict
);
    import swm_pkg::*;

    t_sample          r_mem [MAX_WINDOW];
    t_sample          r_evict;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] next;

    assign slot = (i_start || (CNT_W'(r_ptr) >= i_k)) ? '0 : r_ptr;
    assign next = ((CNT_W'(slot) + CNT_W'(1)) >= i_k) ? '0 : slot + IDX_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_clear) begin
            r_ptr <= '0;
        end else if (i_load) begin
            r_ptr <= next;
        end
    end

    // Write the sample at its slot and prefetch the next eviction; a one-entry ring evicts the sample written now
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_mem[slot] <= i_s;
            r_evict     <= (next == slot) ? i_s : r_mem[next];
        end
    end

    assign o_evict = r_evict;

endmodule

FILE: hdl/sliding_window_median_top.sv
// Sliding window median filter: one sample request per cycle unless stalled.
// A median passes the cell chain, then the output register, before it is valid.
// One request per cycle unless stalled; each updates the sorted cell chain.
// Input stalls only while a median waits behind a held, stalled output.
// Reset (i_rst_n low, synchronous): window empty, window_size 3, output empty.
module sliding_window_median_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swm_pkg::CFG_W-1:0]     i_cfg_wdata,
    swm_sample_if.sink                    i_sample,
    swm_median_if.source                  o_median
);
    import swm_pkg::*;

    // Configuration and fill state
    logic [CFG_W-1:0] r_wsize;
    logic [CNT_W-1:0] r_fill;
    logic [CNT_W-1:0] n_fill;
    logic [CNT_W-1:0] k;
    logic [CNT_W-1:0] fill_eff;
    logic             restart;
    logic             full;
    logic             result;
    logic             accept;

    // Cell chain wiring
    t_cell_ctl        ctl;
    t_sample          evict;
    t_sample          w_val   [MAX_WINDOW];
    t_cell_flags      w_flags [MAX_WINDOW];
    t_sample          w_mid   [MAX_WINDOW];
    t_sample          w_lo    [MAX_WINDOW];
    t_sample          tap_mid;
    t_sample          tap_lo;
    logic [IDX_W-1:0] mid;

    // Output stage
    logic             r_pend;     // chain holds a median not yet registered
    logic             r_out_vld;
    t_median          r_out_med;
    logic             out_load;
    t_median          median;

    assign k = eff_window(r_wsize);

    // start_new empties the window before this sample is placed
    assign restart  = i_sample.start_new || (r_fill > k);
    assign fill_eff = restart ? '0 : r_fill;
    assign full     = (fill_eff == k);
    assign n_fill   = full ? k : fill_eff + CNT_W'(1);
    assign result   = (n_fill == k);

    assign out_load       = r_pend && (!r_out_vld || o_median.ready);
    assign i_sample.ready = !r_pend || out_load;
    assign accept         = i_sample.valid && i_sample.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsize <= WSIZE_RESET;
            r_fill  <= '0;
        end else if (i_cfg_we) begin
            r_wsize <= i_cfg_wdata;
            r_fill  <= '0;
        end else if (accept) begin
            r_fill  <= n_fill;
        end
    end

    // Median taps: odd window uses the middle twice, even the two middles
    assign mid = IDX_W'(k >> 1);

    assign ctl.load   = accept;
    assign ctl.remove = full;
    assign ctl.held   = fill_eff;
    assign ctl.s      = i_sample.sample[SAMPLE_WIDTH-1:0];
    assign ctl.x      = evict;
    assign ctl.mid    = mid;
    assign ctl.lo     = k[0] ? mid : mid - IDX_W'(1);

    swm_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_start (restart),
        .i_clear (i_cfg_we),
        .i_k     (k),
        .i_s     (ctl.s),
        .o_evict (evict)
    );

    // Chain ends: below cell 0 everything counts as smaller, above the
    // last cell nothing is held.
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_sample     lo_val;
        t_cell_flags lo_flags;
        t_sample     hi_val;
        logic        hi_lt;

        if (g == 0) begin : g_first
            assign lo_val   = '0;
            assign lo_flags = '{lt: 1'b1, ge: 1'b0};
        end else begin : g_mid_lo
            assign lo_val   = w_val[g-1];
            assign lo_flags = w_flags[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_last
            assign hi_val = '0;
            assign hi_lt  = 1'b0;
        end else begin : g_mid_hi
            assign hi_val = w_val[g+1];
            assign hi_lt  = w_flags[g+1].lt;
        end

        swm_cell u_cell (
            .i_clk      (i_clk),
            .i_index    (IDX_W'(g)),
            .i_ctl      (ctl),
            .i_lo_val   (lo_val),
            .i_lo_flags (lo_flags),
            .i_hi_val   (hi_val),
            .i_hi_lt    (hi_lt),
            .o_val      (w_val[g]),
            .o_flags    (w_flags[g]),
            .o_mid_tap  (w_mid[g]),
            .o_lo_tap   (w_lo[g])
        );
    end

    // Only the selected cells drive their taps; the rest give zero
    always_comb begin
        tap_mid = '0;
        tap_lo  = '0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            tap_mid = tap_mid | w_mid[i];
            tap_lo  = tap_lo | w_lo[i];
        end
    end

    assign median = OUT_W'(tap_mid) + OUT_W'(tap_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept && result) begin
                r_pend <= 1'b1;
            end else if (out_load) begin
                r_pend <= 1'b0;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_median.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_med <= median;
        end
    end

    assign o_median.valid        = r_out_vld;
    assign o_median.median_twice = r_out_med;

endmodule

FILE: hdl/swm_checker.sv
// Port-level checks for the median filter, bound to the top level.
// Depends on sliding_window_median_top_defines.svh and swm_pkg.
`include "sliding_window_median_top_defines.svh"

module swm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [swm_pkg::OUT_W-1:0]  i_median
);
    import swm_pkg::*;

    // A stalled median holds its value
    `SWM_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_median))

    // Reset empties the output register
    `SWM_ASSERT_ANY(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)

    // Input only stalls behind a held, stalled median
    `SWM_ASSERT(a_ready_cause, i_clk, i_rst_n, !i_in_ready |-> i_out_valid && !i_out_ready)

    // A median appearing on an empty output follows an accepted request
    `SWM_ASSERT(a_out_source, i_clk, i_rst_n, $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_median.valid),
    .i_out_ready (o_median.ready),
    .i_median    (o_median.median_twice)
);
